### hw/rtl/spg_pkg.sv
// ----------------------------------------------------------------------------
// spg_pkg: shared types and constants of the stereo pan gain ramp unit
// Item structs, widths, limits and the quarter-wave cosine table.
// ----------------------------------------------------------------------------
`default_nettype none

package spg_pkg;

   localparam int BLOCK_MAX       = 4096;
   localparam int COS_TABLE_DEPTH = 256;
   localparam int LEN_W           = 13;
   localparam int GAIN_W          = 24;
   localparam int DIV_W           = 24;
   localparam int DIVISOR_W       = 16;
   localparam int CNT_W           = $clog2(DIV_W + 1);
   localparam int COS_IDX_W       = $clog2(COS_TABLE_DEPTH + 1);

   localparam logic [14:0] ANG_45  = 15'd8192;
   localparam logic [14:0] ANG_135 = 15'd24576;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic signed [15:0] sample_in;
      logic               first_of_block;
      logic signed [15:0] azimuth;
      logic [15:0]        distance;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
   } rsp_type;

   typedef logic [15:0] cos_table_type [COS_TABLE_DEPTH];

   // Q2.30 Taylor series to degree 12, rounded to Q1.15.
   function automatic cos_table_type build_cos_table();
      cos_table_type     t;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        q;
      for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
         x    = (64'(i) * HALF_PI_Q30) / 64'(COS_TABLE_DEPTH);
         x2   = (x * x) >> 30;
         term = 64'd1 << 30;
         sum  = $signed(term);
         term = ((term * x2) >> 30) / 64'd2;
         sum  = sum - $signed(term);
         term = ((term * x2) >> 30) / 64'd12;
         sum  = sum + $signed(term);
         term = ((term * x2) >> 30) / 64'd30;
         sum  = sum - $signed(term);
         term = ((term * x2) >> 30) / 64'd56;
         sum  = sum + $signed(term);
         term = ((term * x2) >> 30) / 64'd90;
         sum  = sum - $signed(term);
         term = ((term * x2) >> 30) / 64'd132;
         sum  = sum + $signed(term);
         if (sum < 0) begin
            sum = 64'sd0;
         end
         q = ($unsigned(sum) + 64'd16384) >> 15;
         if (q > 64'd32768) begin
            q = 64'd32768;
         end
         t[i] = q[15:0];
      end
      return t;
   endfunction

   localparam cos_table_type COS_TABLE = build_cos_table();

endpackage

`default_nettype wire

### hw/rtl/spg_divider.sv
// ----------------------------------------------------------------------------
// spg_divider: shared restoring divider
// Unsigned quotient, one bit per cycle, done pulses for one cycle at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [spg_pkg::DIV_W-1:0]      dividend,
   input  wire logic [spg_pkg::DIVISOR_W-1:0]  divisor,
   output logic                                done,
   output logic [spg_pkg::DIV_W-1:0]           quotient
);

   logic [spg_pkg::DIV_W-1:0]     quo_ff;
   logic [spg_pkg::DIVISOR_W-1:0] rem_ff;
   logic [spg_pkg::DIVISOR_W-1:0] div_ff;
   logic [spg_pkg::CNT_W-1:0]     cnt_ff;
   logic                          done_ff;

   logic [spg_pkg::DIVISOR_W:0]   trial;
   logic                          fits;
   logic [spg_pkg::DIVISOR_W:0]   diff;
   logic [spg_pkg::DIVISOR_W-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[spg_pkg::DIV_W-1]};
      fits   = (trial >= {1'b0, div_ff});
      diff   = trial - {1'b0, div_ff};
      rem_in = fits ? diff[spg_pkg::DIVISOR_W-1:0] : trial[spg_pkg::DIVISOR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && (cnt_ff == spg_pkg::CNT_W'(1));
         if (start) begin
            quo_ff <= dividend;
            rem_ff <= '0;
            div_ff <= divisor;
            cnt_ff <= spg_pkg::CNT_W'(spg_pkg::DIV_W);
         end else if (cnt_ff != '0) begin
            quo_ff <= {quo_ff[spg_pkg::DIV_W-2:0], fits};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### hw/rtl/spg_scaler.sv
// ----------------------------------------------------------------------------
// spg_scaler: shared sample-times-gain unit
// Two stages: multiply, then round half up and saturate to Q1.15.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_scaler (
   input  wire logic                             clock,
   input  wire logic signed [15:0]               sample,
   input  wire logic [spg_pkg::GAIN_W-1:0]       gain,
   output logic signed [15:0]                    result
);

   localparam int PROD_W = 16 + spg_pkg::GAIN_W + 1;

   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [15:0]          result_ff;
   logic signed [PROD_W-1:0]    prod_in;
   logic signed [PROD_W-1:0]    rounded;
   logic signed [PROD_W-16:0]   shifted;
   logic signed [15:0]          result_in;

   always_comb begin
      prod_in = PROD_W'(sample * $signed({1'b0, gain}));
      rounded = prod_ff + PROD_W'(16384);
      shifted = rounded[PROD_W-1:15];
      if (shifted > (PROD_W-15)'(32767)) begin
         result_in = 16'sh7FFF;
      end else if (shifted < -(PROD_W-15)'(32768)) begin
         result_in = -16'sh8000;
      end else begin
         result_in = shifted[15:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

### hw/rtl/stereo_pan_gain_ramp_unit.sv
// ----------------------------------------------------------------------------
// stereo_pan_gain_ramp_unit: constant-power mono-to-stereo panner
// Pans Q1.15 mono items to a stereo pair with per-sample gain ramps.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: one mono item per handshake (req_valid high, req_stall low).
//     An item with first_of_block set carries a new azimuth and distance
//     and starts a ramp of block_len items toward the new target gains.
//   rsp_*: one stereo item per input item, taken when rsp_stall is low.
//   csr_*: write block_len (1..4096, 0 acts as 1) while the unit is idle.
// Sequence:
//   A plain item runs through S_MUL_L, S_MUL_R, S_CAP_L and S_OUT; the next
//   item is taken once the unit is back in S_IDLE. The two channel products
//   share one two-stage multiplier.
//   A first_of_block item first runs four divisions (left and right
//   target, left and right step) in that order on one shared bit-serial
//   divider.
//   req_stall is high while an item is in work.
// Reset clears gains, steps and ramp count, and sets block_len to 1.
// A stalled result holds in the output register; the unit finishes the next
// item and then holds it until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_pan_gain_ramp_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire spg_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output spg_pkg::rsp_type       rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [spg_pkg::LEN_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_MUL_L,
      S_MUL_R,
      S_CAP_L,
      S_OUT
   } state_type;

   // Which division the shared divider is running
   typedef enum logic [1:0] {
      OP_TL,
      OP_TR,
      OP_SL,
      OP_SR
   } op_type;

   localparam int GW  = spg_pkg::GAIN_W;
   localparam int APW = 15 + $clog2(spg_pkg::COS_TABLE_DEPTH) + 1;
   localparam int COS_IDX_W_L = spg_pkg::COS_IDX_W;

   state_type               state_ff;
   op_type                  op_ff;
   spg_pkg::req_type        item_ff;
   logic [spg_pkg::LEN_W-1:0] block_len_ff;
   logic [GW-1:0]           gain_left_ff;
   logic [GW-1:0]           gain_right_ff;
   logic signed [GW-1:0]    step_left_ff;
   logic signed [GW-1:0]    step_right_ff;
   logic [spg_pkg::LEN_W-1:0] ramp_left_count_ff;
   logic [GW-1:0]           target_left_ff;
   logic [GW-1:0]           target_right_ff;
   logic signed [15:0]      left_res_ff;
   logic                    rsp_valid_ff;
   spg_pkg::rsp_type        rsp_data_ff;

   logic [spg_pkg::LEN_W-1:0]   len_eff;
   logic [15:0]                 dist_eff;
   logic [16:0]                 az_mag;
   logic [14:0]                 mag;
   logic [14:0]                 angle;
   logic [APW-1:0]              ang_prod;
   logic [COS_IDX_W_L-1:0]      cos_idx;
   logic [15:0]                 cos_val;
   logic [GW-1:0]               numer;
   logic [GW-1:0]               tgt_sel;
   logic [GW-1:0]               gain_sel;
   logic signed [GW+1:0]        diff;
   logic signed [GW+1:0]        diff_abs;
   logic                        diff_neg;
   logic [spg_pkg::DIV_W-1:0]   div_dividend;
   logic [spg_pkg::DIVISOR_W-1:0] div_divisor;
   logic                        div_start;
   logic                        div_done;
   logic [spg_pkg::DIV_W-1:0]   div_quo;
   logic signed [GW-1:0]        step_in;
   logic [GW-1:0]               scale_gain;
   logic signed [15:0]          scale_res;
   logic [GW-1:0]               gain_left_in;
   logic [GW-1:0]               gain_right_in;
   logic                        rsp_load;

   // Gain plus step, clamped to the unsigned gain range
   function automatic logic [GW-1:0] advance_gain(input logic [GW-1:0] g,
                                                  input logic signed [GW-1:0] s);
      logic signed [GW+1:0] sum;
      sum = $signed({2'b00, g}) + (GW+2)'(s);
      if (sum < 0) begin
         return '0;
      end else if (sum > $signed({2'b00, {GW{1'b1}}})) begin
         return {GW{1'b1}};
      end else begin
         return sum[GW-1:0];
      end
   endfunction

   // Effective operands: clamp length, treat zero distance as one lsb
   always_comb begin
      if (block_len_ff == '0) begin
         len_eff = spg_pkg::LEN_W'(1);
      end else if (block_len_ff > spg_pkg::LEN_W'(spg_pkg::BLOCK_MAX)) begin
         len_eff = spg_pkg::LEN_W'(spg_pkg::BLOCK_MAX);
      end else begin
         len_eff = block_len_ff;
      end
      dist_eff = (item_ff.distance == 16'd0) ? 16'd1 : item_ff.distance;
   end

   // Fold azimuth to its magnitude, clamp to 45..135 degrees, look up cosine
   always_comb begin
      az_mag = item_ff.azimuth[15] ? (17'd0 - {item_ff.azimuth[15], item_ff.azimuth})
                                   : {1'b0, item_ff.azimuth};
      if (az_mag > {2'b00, spg_pkg::ANG_135}) begin
         mag = spg_pkg::ANG_135;
      end else if (az_mag < {2'b00, spg_pkg::ANG_45}) begin
         mag = spg_pkg::ANG_45;
      end else begin
         mag = az_mag[14:0];
      end
      angle    = (op_ff == OP_TL) ? (spg_pkg::ANG_135 - mag) : (mag - spg_pkg::ANG_45);
      ang_prod = APW'(angle) * APW'(spg_pkg::COS_TABLE_DEPTH) + APW'(8192);
      cos_idx  = COS_IDX_W_L'(ang_prod >> 14);
      if (cos_idx >= COS_IDX_W_L'(spg_pkg::COS_TABLE_DEPTH)) begin
         cos_val = 16'd0;
      end else begin
         cos_val = spg_pkg::COS_TABLE[cos_idx[COS_IDX_W_L-2:0]];
      end
      numer = {cos_val[GW-9:0], 8'd0} + GW'(dist_eff >> 1);
   end

   // Step operands: signed difference of target and current gain
   always_comb begin
      tgt_sel  = (op_ff == OP_SL) ? target_left_ff : target_right_ff;
      gain_sel = (op_ff == OP_SL) ? gain_left_ff : gain_right_ff;
      diff     = $signed({2'b00, tgt_sel}) - $signed({2'b00, gain_sel});
      diff_neg = diff[GW+1];
      diff_abs = diff_neg ? -diff : diff;
   end

   always_comb begin
      unique case (op_ff)
         OP_TL, OP_TR: begin
            div_dividend = numer;
            div_divisor  = dist_eff;
         end
         OP_SL, OP_SR: begin
            div_dividend = diff_abs[GW-1:0];
            div_divisor  = spg_pkg::DIVISOR_W'(len_eff);
         end
         default: begin
            div_dividend = numer;
            div_divisor  = dist_eff;
         end
      endcase
   end

   // Truncated quotient with the sign restored, saturated to the step range
   always_comb begin
      if (diff_neg) begin
         if (div_quo > {1'b1, {(GW-1){1'b0}}}) begin
            step_in = $signed({1'b1, {(GW-1){1'b0}}});
         end else begin
            step_in = $signed(GW'(0) - div_quo);
         end
      end else begin
         if (div_quo > {1'b0, {(GW-1){1'b1}}}) begin
            step_in = $signed({1'b0, {(GW-1){1'b1}}});
         end else begin
            step_in = $signed(div_quo);
         end
      end
   end

   assign div_start  = (state_ff == S_DIV_GO);
   assign scale_gain = (state_ff == S_MUL_L) ? gain_left_ff : gain_right_ff;
   // Hand off when the output register is empty or being taken this cycle
   assign rsp_load   = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      gain_left_in  = advance_gain(gain_left_ff, step_left_ff);
      gain_right_in = advance_gain(gain_right_ff, step_right_ff);
   end

   spg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   spg_scaler u_scaler (
      .clock  (clock),
      .sample (item_ff.sample_in),
      .gain   (scale_gain),
      .result (scale_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         op_ff              <= OP_TL;
         block_len_ff       <= spg_pkg::LEN_W'(1);
         gain_left_ff       <= '0;
         gain_right_ff      <= '0;
         step_left_ff       <= '0;
         step_right_ff      <= '0;
         ramp_left_count_ff <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         // Take the register write whenever it comes
         if (csr_valid) begin
            block_len_ff <= csr_data;
         end
         // Raise valid on a hand-off, drop it once the receiver takes the item
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff <= req_data;
                  op_ff   <= OP_TL;
                  state_ff <= req_data.first_of_block ? S_DIV_GO : S_MUL_L;
               end
            end
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  unique case (op_ff)
                     OP_TL: begin
                        target_left_ff <= div_quo;
                        op_ff          <= OP_TR;
                        state_ff       <= S_DIV_GO;
                     end
                     OP_TR: begin
                        target_right_ff <= div_quo;
                        op_ff           <= OP_SL;
                        state_ff        <= S_DIV_GO;
                     end
                     OP_SL: begin
                        step_left_ff <= step_in;
                        op_ff        <= OP_SR;
                        state_ff     <= S_DIV_GO;
                     end
                     OP_SR: begin
                        step_right_ff      <= step_in;
                        ramp_left_count_ff <= len_eff;
                        state_ff           <= S_MUL_L;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_MUL_L: begin
               state_ff <= S_MUL_R;
            end
            S_MUL_R: begin
               state_ff <= S_CAP_L;
            end
            S_CAP_L: begin
               left_res_ff <= scale_res;
               state_ff    <= S_OUT;
            end
            S_OUT: begin
               // Hold until the output register is free, then hand off and ramp
               if (rsp_load) begin
                  rsp_data_ff.left_out  <= left_res_ff;
                  rsp_data_ff.right_out <= scale_res;
                  if (ramp_left_count_ff != '0) begin
                     gain_left_ff       <= gain_left_in;
                     gain_right_ff      <= gain_right_in;
                     ramp_left_count_ff <= ramp_left_count_ff - 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != S_IDLE)
      else $error("accepted item did not start work");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV_WAIT)
      else $error("divider finished outside a division wait");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside the hand-off state");

   a_ramp_bounded: assert property (@(posedge clock) disable iff (reset)
      ramp_left_count_ff <= spg_pkg::LEN_W'(spg_pkg::BLOCK_MAX))
      else $error("ramp count beyond the longest block");

   a_ramp_counts_down: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall) && ramp_left_count_ff != '0
      |=> ramp_left_count_ff == $past(ramp_left_count_ff) - 1'b1)
      else $error("ramp count did not advance on hand-off");
`endif

endmodule

`default_nettype wire
